FILE: hdl/tsz_pkg.sv
// Shared constants, types and state codes of the triangle rasterizer.
`default_nettype none
package tsz_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 128;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);

    localparam int SW_W       = 9;
    localparam int SH_W       = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);
    localparam logic [SW_W-1:0]      SW_RESET          = SW_W'(120);
    localparam logic [SH_W-1:0]      SH_RESET          = SH_W'(30);

    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam int XA_W    = 36;
    localparam int ZA_W    = 44;
    localparam int Q_W     = 42;
    localparam int DEN_W   = 14;
    localparam int Y_W     = 14;
    localparam int CNT_W   = $clog2(Q_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic signed [15:0] x2;
        logic signed [23:0] z0;
        logic signed [23:0] z1;
        logic signed [23:0] z2;
        logic signed [12:0] r0;
        logic signed [12:0] r1;
        logic signed [12:0] r2;
        logic signed [15:0] rd_y;
        logic [15:0]        color;
    } t_cmd;

    typedef struct packed {
        logic [SW_W-1:0] width;
        logic [SH_W-1:0] height;
    } t_screen;

    typedef struct packed {
        logic                  start;
        logic signed [Q_W-1:0] num;
        logic [DEN_W-1:0]      den;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DSTART,
        S_DWAIT,
        S_ROW,
        S_SDIV,
        S_PIX,
        S_PIXWR
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/triangle_scanline_zbuffer_fill.sv
// Top level of the scanline triangle rasterizer with depth and color stores.
// After reset, and after every clear transaction, the stores are swept one entry per
// cycle over all 32768 entries before the next queued item is started; transactions are
// still queued meanwhile. A draw first runs the x and z slope division of each edge on
// the shared serial divider, then steps each row from the top vertex row to the bottom
// vertex row or the last visible row, whichever is first: rows above the screen are
// skipped, and each visible row runs a span division, then for each on-screen pixel a
// depth-store read and then a compare and write, skipping columns left of the screen.
`default_nettype none
module triangle_scanline_zbuffer_fill (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [15:0]                   i_x0,
    input  wire logic [15:0]                   i_y0,
    input  wire logic [23:0]                   i_z0,
    input  wire logic [15:0]                   i_x1,
    input  wire logic [15:0]                   i_y1,
    input  wire logic [23:0]                   i_z1,
    input  wire logic [15:0]                   i_x2,
    input  wire logic [15:0]                   i_y2,
    input  wire logic [23:0]                   i_z2,
    input  wire logic [15:0]                   i_fill_color,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [15:0]                        o_pixel_color,
    output logic [23:0]                        o_pixel_depth,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tsz_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tsz_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsz_pkg::*;

    logic [SW_W-1:0] r_screen_width;
    logic [SH_W-1:0] r_screen_height;
    t_screen         screen;
    t_cmd            front_cmd;
    t_cmd            q_cmd;
    logic            push, full, pop, empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SW_RESET;
            r_screen_height <= SH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[SW_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        screen.width  = (r_screen_width < SW_W'(MAX_WIDTH)) ? r_screen_width
                                                            : SW_W'(MAX_WIDTH);
        screen.height = ({1'b0, r_screen_height} < (SH_W + 1)'(MAX_HEIGHT)) ?
                        r_screen_height : SH_W'(MAX_HEIGHT);
    end

    tsz_front u_front (
        .i_in_valid   (i_in_valid),
        .i_mode       (i_mode),
        .i_x0         (i_x0),
        .i_y0         (i_y0),
        .i_z0         (i_z0),
        .i_x1         (i_x1),
        .i_y1         (i_y1),
        .i_z1         (i_z1),
        .i_x2         (i_x2),
        .i_y2         (i_y2),
        .i_z2         (i_z2),
        .i_fill_color (i_fill_color),
        .i_full       (full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    tsz_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (q_cmd)
    );

    tsz_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_screen      (screen),
        .i_q_empty     (empty),
        .i_q_cmd       (q_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_pixel_depth (o_pixel_depth)
    );

endmodule
`default_nettype wire

FILE: hdl/tsz_div.sv
// Serial signed divider with truncation toward zero, one quotient bit per cycle.
`default_nettype none
module tsz_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tsz_pkg::t_div_req i_req,
    output tsz_pkg::t_div_rsp      o_rsp
);
    import tsz_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W:0]       r_rem;
    logic [Q_W-1:0]       r_quo;
    logic [DEN_W-1:0]     r_den;
    logic                 r_neg;
    logic                 r_zero;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;
    logic [Q_W-1:0]       mag;

    assign mag    = i_req.num[Q_W-1] ? Q_W'(-i_req.num) : i_req.num;
    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[Q_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= mag;
            r_den  <= i_req.den;
            r_neg  <= i_req.num[Q_W-1];
            r_zero <= (i_req.den == '0);
        end else if (r_busy) begin
            r_rem <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
            r_quo <= {r_quo[Q_W-2:0], fits};
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.quo = '0;
        end else if (r_neg) begin
            o_rsp.quo = Q_W'(-r_quo);
        end else begin
            o_rsp.quo = r_quo;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tsz_front.sv
// Front end: accepts items, drops unused modes, sorts vertices by y and rounds rows.
`default_nettype none
module tsz_front (
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_x0,
    input  wire logic [15:0] i_y0,
    input  wire logic [23:0] i_z0,
    input  wire logic [15:0] i_x1,
    input  wire logic [15:0] i_y1,
    input  wire logic [23:0] i_z1,
    input  wire logic [15:0] i_x2,
    input  wire logic [15:0] i_y2,
    input  wire logic [23:0] i_z2,
    input  wire logic [15:0] i_fill_color,
    input  wire logic        i_full,
    output logic             o_in_stall,
    output logic             o_push,
    output tsz_pkg::t_cmd    o_cmd
);
    import tsz_pkg::*;

    function automatic logic signed [12:0] round_row(input logic signed [15:0] y);
        logic [16:0] mag;
        logic [16:0] t;
        mag = y[15] ? 17'(-{y[15], y}) : {1'b0, y};
        t   = (mag + 17'd8) >> 4;
        round_row = y[15] ? 13'(-t[12:0]) : t[12:0];
    endfunction

    logic signed [15:0] sx [3];
    logic signed [15:0] sy [3];
    logic signed [23:0] sz [3];
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [23:0] tz;

    always_comb begin
        sx[0] = i_x0; sy[0] = i_y0; sz[0] = i_z0;
        sx[1] = i_x1; sy[1] = i_y1; sz[1] = i_z1;
        sx[2] = i_x2; sy[2] = i_y2; sz[2] = i_z2;
        tx = '0; ty = '0; tz = '0;
        if (sy[1] < sy[0]) begin
            tx = sx[0]; ty = sy[0]; tz = sz[0];
            sx[0] = sx[1]; sy[0] = sy[1]; sz[0] = sz[1];
            sx[1] = tx; sy[1] = ty; sz[1] = tz;
        end
        if (sy[2] < sy[0]) begin
            tx = sx[0]; ty = sy[0]; tz = sz[0];
            sx[0] = sx[2]; sy[0] = sy[2]; sz[0] = sz[2];
            sx[2] = tx; sy[2] = ty; sz[2] = tz;
        end
        if (sy[2] < sy[1]) begin
            tx = sx[1]; ty = sy[1]; tz = sz[1];
            sx[1] = sx[2]; sy[1] = sy[2]; sz[1] = sz[2];
            sx[2] = tx; sy[2] = ty; sz[2] = tz;
        end
    end

    always_comb begin
        o_cmd.mode  = i_mode;
        o_cmd.color = i_fill_color;
        o_cmd.rd_y  = i_y0;
        o_cmd.r0    = round_row(sy[0]);
        o_cmd.r1    = round_row(sy[1]);
        o_cmd.r2    = round_row(sy[2]);
        o_cmd.z0    = sz[0];
        o_cmd.z1    = sz[1];
        o_cmd.z2    = sz[2];
        o_cmd.x1    = sx[1];
        o_cmd.x2    = sx[2];
        o_cmd.x0    = (i_mode == MODE_DRAW) ? sx[0] : i_x0;
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full &&
                        (i_mode == MODE_DRAW || i_mode == MODE_READ || i_mode == MODE_CLEAR);

endmodule
`default_nettype wire

FILE: hdl/tsz_queue.sv
// Short command queue between the front end and the draw engine.
`default_nettype none
module tsz_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tsz_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output tsz_pkg::t_cmd      o_cmd
);
    import tsz_pkg::*;

    t_cmd                r_ent [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tsz_back.sv
// Draw engine: edge setup, row stepping, span fill, pixel reads and store clearing.
`default_nettype none
module tsz_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tsz_pkg::t_screen i_screen,
    input  wire logic             i_q_empty,
    input  wire tsz_pkg::t_cmd    i_q_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [15:0]           o_pixel_color,
    output logic [23:0]           o_pixel_depth
);
    import tsz_pkg::*;

    localparam logic [XA_W-1:0] HALF_Q20 = XA_W'(1) << 19;

    function automatic logic signed [15:0] round_q20(input logic signed [XA_W-1:0] v);
        logic [XA_W-1:0] mag;
        logic [XA_W-1:0] t;
        mag = v[XA_W-1] ? XA_W'(-v) : v;
        t   = (mag + HALF_Q20) >> 20;
        round_q20 = v[XA_W-1] ? 16'(-t[15:0]) : t[15:0];
    endfunction

    t_state                 r_state;
    t_state                 n_state;
    t_cmd                   r_cmd;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [2:0]             r_didx;
    logic signed [XA_W-1:0] r_dx02, r_dx01, r_dx12;
    logic signed [Q_W-1:0]  r_dz02, r_dz01, r_dz12;
    logic signed [XA_W-1:0] r_lx, r_sx;
    logic signed [ZA_W-1:0] r_lz, r_sz;
    logic                   r_supper;
    logic signed [Y_W-1:0]  r_y, r_yhi;
    logic signed [15:0]     r_c, r_chi, r_xs;
    logic signed [23:0]     r_zs;
    logic signed [Q_W-1:0]  r_dzs;
    logic signed [ZA_W-1:0] r_sacc;
    logic signed [23:0]     r_zpix;
    logic [ADDR_W-1:0]      r_addr;
    logic                   r_out_valid;
    logic [15:0]            r_pixel_color;
    logic [23:0]            r_pixel_depth;
    logic [39:0]            r_mem [STORE_DEPTH];
    logic [39:0]            r_rd_data;

    t_div_req               div_req;
    t_div_rsp               div_rsp;

    logic                   out_free;
    logic                   rd_in_range;
    logic signed [16:0]     w_s, h_s;
    logic signed [15:0]     lxr, sxr, xs, xf, w_m1;
    logic signed [23:0]     lzr, szr, zs, ze;
    logic signed [24:0]     dzd;
    logic signed [16:0]     span;
    logic                   row_done, row_skip, pix_end, pix_skip;
    logic [ROW_BITS-1:0]    row_sel;
    logic [COL_BITS-1:0]    col_sel;
    logic [ADDR_W-1:0]      mem_raddr, mem_waddr;
    logic                   mem_we;
    logic [39:0]            mem_wdata;
    logic signed [16:0]     ex_d;
    logic signed [24:0]     ez_d;
    logic signed [13:0]     er_d;
    logic signed [15:0]     ex_a, ex_b;
    logic signed [23:0]     ez_a, ez_b;
    logic signed [12:0]     er_a, er_b;
    logic signed [Y_W-1:0]  y_next, h_m1, r2_ext;

    tsz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign w_s      = {8'b0, i_screen.width};
    assign h_s      = {9'b0, i_screen.height};
    assign w_m1     = 16'(w_s - 17'sd1);
    assign h_m1     = Y_W'(h_s - 17'sd1);
    assign r2_ext   = Y_W'(r_cmd.r2);

    assign rd_in_range = !i_q_cmd.x0[15] && !i_q_cmd.rd_y[15] &&
                         ({i_q_cmd.x0[15], i_q_cmd.x0} < w_s) &&
                         ({i_q_cmd.rd_y[15], i_q_cmd.rd_y} < h_s);

    always_comb begin
        lxr  = round_q20(r_lx);
        sxr  = round_q20(r_sx);
        lzr  = r_lz[39:16];
        szr  = r_sz[39:16];
        if (lxr < sxr) begin
            xs = lxr;
            xf = sxr;
        end else begin
            xs = sxr;
            xf = lxr;
        end
        if (xs == lxr) begin
            zs = lzr;
            ze = szr;
        end else begin
            zs = szr;
            ze = lzr;
        end
        dzd  = 25'({ze[23], ze} - {zs[23], zs});
        span = 17'({xf[15], xf} - {xs[15], xs});
    end

    assign row_done = r_y > r_yhi;
    assign row_skip = r_y[Y_W-1];
    assign pix_end  = r_c > r_chi;
    assign pix_skip = r_c[15];
    assign y_next   = r_y + Y_W'(1);

    always_comb begin
        ex_a = r_cmd.x0; ex_b = r_cmd.x2;
        ez_a = r_cmd.z0; ez_b = r_cmd.z2;
        er_a = r_cmd.r0; er_b = r_cmd.r2;
        case (r_didx)
            3'd2, 3'd3: begin
                ex_b = r_cmd.x1; ez_b = r_cmd.z1; er_b = r_cmd.r1;
            end
            3'd4, 3'd5: begin
                ex_a = r_cmd.x1; ez_a = r_cmd.z1; er_a = r_cmd.r1;
            end
            default: begin
            end
        endcase
        ex_d = 17'({ex_b[15], ex_b} - {ex_a[15], ex_a});
        ez_d = 25'({ez_b[23], ez_b} - {ez_a[23], ez_a});
        er_d = 14'({er_b[12], er_b} - {er_a[12], er_a});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_cmd.mode)
                        MODE_DRAW:  n_state = S_DSTART;
                        MODE_READ:  begin
                            if (out_free && rd_in_range) begin
                                n_state = S_READ;
                            end
                        end
                        MODE_CLEAR: n_state = S_CLEAR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:   n_state = S_IDLE;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_didx == 3'd5) ? S_ROW : S_DSTART;
                end
            end
            S_ROW: begin
                if (row_done) begin
                    n_state = S_IDLE;
                end else if (!row_skip) begin
                    n_state = S_SDIV;
                end
            end
            S_SDIV: begin
                if (div_rsp.done) begin
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                if (pix_end) begin
                    n_state = S_ROW;
                end else if (!pix_skip) begin
                    n_state = S_PIXWR;
                end
            end
            S_PIXWR:  n_state = S_PIX;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == S_IDLE) && !i_q_empty &&
                (i_q_cmd.mode != MODE_READ || out_free);
        if (r_state == S_IDLE) begin
            row_sel = i_q_cmd.rd_y[ROW_BITS-1:0];
            col_sel = i_q_cmd.x0[COL_BITS-1:0];
        end else begin
            row_sel = r_y[ROW_BITS-1:0];
            col_sel = r_c[COL_BITS-1:0];
        end
        mem_raddr = ADDR_W'(i_screen.width * row_sel) + ADDR_W'(col_sel);
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {r_zpix, r_cmd.color};
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_PIXWR: mem_we = $signed(r_rd_data[39:16]) < r_zpix;
            default: begin
            end
        endcase
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        if (r_state == S_ROW) begin
            div_req.start = !row_done && !row_skip;
            div_req.num   = {{(Q_W - 41){dzd[24]}}, dzd, 16'b0};
            div_req.den   = span[DEN_W-1:0];
        end else begin
            div_req.start = (r_state == S_DSTART);
            div_req.den   = er_d[DEN_W-1:0];
            if (r_didx[0]) begin
                div_req.num = {{(Q_W - 41){ez_d[24]}}, ez_d, 16'b0};
            end else begin
                div_req.num = {{(Q_W - 33){ex_d[16]}}, ex_d, 16'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_IDLE && o_pop && i_q_cmd.mode == MODE_CLEAR) begin
                r_clr_addr <= '0;
            end
            if (r_state == S_READ ||
                (r_state == S_IDLE && o_pop && i_q_cmd.mode == MODE_READ && !rd_in_range)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_cmd  <= i_q_cmd;
                    r_didx <= '0;
                    if (i_q_cmd.mode == MODE_READ && !rd_in_range) begin
                        r_pixel_color <= '0;
                        r_pixel_depth <= '0;
                    end
                end
            end
            S_READ: begin
                r_pixel_color <= r_rd_data[15:0];
                r_pixel_depth <= r_rd_data[39:16];
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    r_didx <= r_didx + 3'd1;
                    case (r_didx)
                        3'd0:    r_dx02 <= div_rsp.quo[XA_W-1:0];
                        3'd1:    r_dz02 <= div_rsp.quo;
                        3'd2:    r_dx01 <= div_rsp.quo[XA_W-1:0];
                        3'd3:    r_dz01 <= div_rsp.quo;
                        3'd4:    r_dx12 <= div_rsp.quo[XA_W-1:0];
                        default: r_dz12 <= div_rsp.quo;
                    endcase
                    if (r_didx == 3'd5) begin
                        r_y   <= Y_W'(r_cmd.r0);
                        r_yhi <= (r2_ext < h_m1) ? r2_ext : h_m1;
                        r_lx  <= {{(XA_W - 32){r_cmd.x0[15]}}, r_cmd.x0, 16'b0};
                        r_lz  <= {{(ZA_W - 40){r_cmd.z0[23]}}, r_cmd.z0, 16'b0};
                        if (r_cmd.r0 < r_cmd.r1) begin
                            r_supper <= 1'b1;
                            r_sx <= {{(XA_W - 32){r_cmd.x0[15]}}, r_cmd.x0, 16'b0};
                            r_sz <= {{(ZA_W - 40){r_cmd.z0[23]}}, r_cmd.z0, 16'b0};
                        end else begin
                            r_supper <= 1'b0;
                            r_sx <= {{(XA_W - 32){r_cmd.x1[15]}}, r_cmd.x1, 16'b0};
                            r_sz <= {{(ZA_W - 40){r_cmd.z1[23]}}, r_cmd.z1, 16'b0};
                        end
                    end
                end
            end
            S_ROW: begin
                r_xs  <= xs;
                r_zs  <= zs;
                r_chi <= (xf < w_m1) ? xf : w_m1;
            end
            S_SDIV: begin
                r_dzs  <= div_rsp.quo;
                r_c    <= r_xs;
                r_sacc <= {{(ZA_W - 40){r_zs[23]}}, r_zs, 16'b0};
            end
            S_PIX: begin
                if (!pix_end) begin
                    r_c    <= r_c + 16'sd1;
                    r_sacc <= r_sacc + {{(ZA_W - Q_W){r_dzs[Q_W-1]}}, r_dzs};
                    r_addr <= mem_raddr;
                    r_zpix <= r_sacc[39:16];
                end
            end
            default: begin
            end
        endcase
        if ((r_state == S_ROW && !row_done && row_skip) ||
            (r_state == S_PIX && pix_end)) begin
            r_y  <= y_next;
            r_lx <= r_lx + r_dx02;
            r_lz <= r_lz + {{(ZA_W - Q_W){r_dz02[Q_W-1]}}, r_dz02};
            if (r_supper && y_next == Y_W'(r_cmd.r1)) begin
                r_supper <= 1'b0;
                r_sx <= {{(XA_W - 32){r_cmd.x1[15]}}, r_cmd.x1, 16'b0};
                r_sz <= {{(ZA_W - 40){r_cmd.z1[23]}}, r_cmd.z1, 16'b0};
            end else if (r_supper) begin
                r_sx <= r_sx + r_dx01;
                r_sz <= r_sz + {{(ZA_W - Q_W){r_dz01[Q_W-1]}}, r_dz01};
            end else begin
                r_sx <= r_sx + r_dx12;
                r_sz <= r_sz + {{(ZA_W - Q_W){r_dz12[Q_W-1]}}, r_dz12};
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_color = r_pixel_color;
    assign o_pixel_depth = r_pixel_depth;

endmodule
`default_nettype wire
